/* sv/huffman_tree_decoder_defines.svh */
// Assertion macros used by the checker file of the Huffman tree decoder.
// Depends on nothing; include by bare file name.
`ifndef HUFFMAN_TREE_DECODER_DEFINES_SVH
`define HUFFMAN_TREE_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HTD_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HTD_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

/* sv/htd_pkg.sv */
// Package of the Huffman tree decoder: field widths, command and status codes,
// datapath operations and the status struct. Depends on nothing.
package htd_pkg;

    localparam int CMD_W      = 2;
    localparam int SYM_W      = 8;
    localparam int CODE_W     = 32;
    localparam int CODE_IDX_W = 5;
    localparam int LEN_W      = 6;
    localparam int STATUS_W   = 2;

    localparam int NODE_COUNT_DEF   = 512;
    localparam int MAX_CODE_LEN_DEF = 32;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DECODE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_NONE   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SYMBOL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_INIT_ROOT,
        DP_LOAD,
        DP_CLEAR,
        DP_ADD_STEP,
        DP_ADD_LINK,
        DP_ADD_NEW,
        DP_ADD_SYM,
        DP_ADD_FULL,
        DP_DEC_STEP,
        DP_DEC_CHECK,
        DP_OUT_LOAD
    } t_dp_op;

    typedef struct packed {
        logic [CMD_W-1:0] new_cmd;
        logic             rem_zero;
        logic             child_present;
        logic             table_full;
        logic             out_free;
    } t_dp_stat;

endpackage

/* sv/htd_if.sv */
// Channel interfaces of the Huffman tree decoder: command input and result output.
// Depends on htd_pkg.
interface htd_in_if;
    logic                        valid;
    logic                        ready;
    logic [htd_pkg::CMD_W-1:0]   cmd;
    logic [htd_pkg::SYM_W-1:0]   symbol;
    logic [htd_pkg::CODE_W-1:0]  code_bits;
    logic [htd_pkg::LEN_W-1:0]   code_length;
    logic                        code_bit;

    modport source (output valid, cmd, symbol, code_bits, code_length, code_bit,
                    input ready);
    modport sink   (input valid, cmd, symbol, code_bits, code_length, code_bit,
                    output ready);
endinterface

interface htd_out_if;
    logic                          valid;
    logic                          ready;
    logic [htd_pkg::STATUS_W-1:0]  status;
    logic [htd_pkg::SYM_W-1:0]     out_symbol;

    modport source (output valid, status, out_symbol, input ready);
    modport sink   (input valid, status, out_symbol, output ready);
endinterface

/* sv/huffman_tree_decoder.sv */
// Channel      Direction  Payload
// i_in         sink       cmd, symbol, code_bits, code_length, code_bit
// o_out        source     status, out_symbol
//
// One item is in work at a time. Clear passes through S_CLEAR and S_FIN; decode
// through S_DEC_RD, S_DEC_EV and S_FIN, with S_DEC_CRD and S_DEC_CHK when the
// bit steps to a child. Add passes through S_ADD_RD and S_ADD_EV for each code
// bit, plus S_ADD_NEW for each node it creates. Each step waits on the
// registered read of the node memory. After reset the root is written in S_INIT
// before the first transfer. A waiting o_out result holds the next item in S_FIN.
// Top level of the Huffman tree decoder; depends on htd_pkg, htd_if,
// htd_ctrl and htd_datapath.
module huffman_tree_decoder #(
    parameter int NODE_COUNT   = htd_pkg::NODE_COUNT_DEF,
    parameter int MAX_CODE_LEN = htd_pkg::MAX_CODE_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    htd_in_if.sink     i_in,
    htd_out_if.source  o_out
);

    htd_pkg::t_dp_op   dp_op;
    htd_pkg::t_dp_stat dp_stat;

    htd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (dp_stat),
        .o_op       (dp_op)
    );

    htd_datapath #(
        .NODE_COUNT   (NODE_COUNT),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (dp_op),
        .o_stat        (dp_stat),
        .i_cmd         (i_in.cmd),
        .i_symbol      (i_in.symbol),
        .i_code_bits   (i_in.code_bits),
        .i_code_length (i_in.code_length),
        .i_code_bit    (i_in.code_bit),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_status      (o_out.status),
        .o_out_symbol  (o_out.out_symbol)
    );

endmodule

/* sv/htd_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module htd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/htd_datapath.sv */
// Datapath of the Huffman tree decoder: item registers, node memory, tree
// pointers and the output register. Depends on htd_pkg and htd_ram.
module htd_datapath #(
    parameter int NODE_COUNT   = htd_pkg::NODE_COUNT_DEF,
    parameter int MAX_CODE_LEN = htd_pkg::MAX_CODE_LEN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  htd_pkg::t_dp_op               i_op,
    output htd_pkg::t_dp_stat             o_stat,
    input  logic [htd_pkg::CMD_W-1:0]     i_cmd,
    input  logic [htd_pkg::SYM_W-1:0]     i_symbol,
    input  logic [htd_pkg::CODE_W-1:0]    i_code_bits,
    input  logic [htd_pkg::LEN_W-1:0]     i_code_length,
    input  logic                          i_code_bit,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [htd_pkg::STATUS_W-1:0]  o_status,
    output logic [htd_pkg::SYM_W-1:0]     o_out_symbol
);

    localparam int IDXW   = $clog2(NODE_COUNT);
    localparam int CNTW   = $clog2(NODE_COUNT + 1);
    localparam int NODE_W = 2 + 2 * IDXW + htd_pkg::SYM_W;

    typedef struct packed {
        logic                       has_l;
        logic                       has_r;
        logic [IDXW-1:0]            left;
        logic [IDXW-1:0]            right;
        logic [htd_pkg::SYM_W-1:0]  sym;
    } t_node;

    logic [htd_pkg::CMD_W-1:0]    r_cmd;
    logic [htd_pkg::SYM_W-1:0]    r_sym;
    logic [htd_pkg::CODE_W-1:0]   r_code;
    logic                         r_code_bit;
    logic [htd_pkg::LEN_W-1:0]    r_rem,        n_rem;
    logic [IDXW-1:0]              r_node,       n_node;
    logic [CNTW-1:0]              r_used,       n_used;
    logic [IDXW-1:0]              r_walk,       n_walk;
    logic [htd_pkg::STATUS_W-1:0] r_res_status, n_res_status;
    logic [htd_pkg::SYM_W-1:0]    r_res_sym,    n_res_sym;
    logic                         r_out_valid,  n_out_valid;
    logic [htd_pkg::STATUS_W-1:0] r_out_status;
    logic [htd_pkg::SYM_W-1:0]    r_out_sym;

    logic [NODE_W-1:0]            ram_rdata;
    t_node                        rd_node;
    t_node                        wr_node;
    logic                         wr_en;
    logic [IDXW-1:0]              wr_addr;
    logic [htd_pkg::LEN_W-1:0]    bit_pos;
    logic                         add_bit;
    logic                         step_bit;
    logic                         child_present;
    logic [IDXW-1:0]              child_idx;
    logic [IDXW-1:0]              new_idx;
    logic [htd_pkg::LEN_W-1:0]    len_clip;
    logic                         out_free;

    htd_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_node),
        .i_raddr (r_node),
        .o_rdata (ram_rdata)
    );

    assign rd_node  = t_node'(ram_rdata);
    assign bit_pos  = r_rem - htd_pkg::LEN_W'(1);
    assign add_bit  = (bit_pos < htd_pkg::LEN_W'(htd_pkg::CODE_W))
                      ? r_code[bit_pos[htd_pkg::CODE_IDX_W-1:0]] : 1'b0;
    assign step_bit = (r_cmd == htd_pkg::CMD_DECODE) ? r_code_bit : add_bit;
    assign child_present = step_bit ? rd_node.has_r : rd_node.has_l;
    assign child_idx     = step_bit ? rd_node.right : rd_node.left;
    assign new_idx       = r_used[IDXW-1:0];
    assign len_clip = ({1'b0, i_code_length} > (htd_pkg::LEN_W + 1)'(MAX_CODE_LEN))
                      ? htd_pkg::LEN_W'(MAX_CODE_LEN) : i_code_length;
    assign out_free = !r_out_valid || i_out_ready;

    assign o_stat.new_cmd       = i_cmd;
    assign o_stat.rem_zero      = (r_rem == '0);
    assign o_stat.child_present = child_present;
    assign o_stat.table_full    = (r_used == CNTW'(NODE_COUNT));
    assign o_stat.out_free      = out_free;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_node;
        wr_node = rd_node;
        case (i_op)
            htd_pkg::DP_INIT_ROOT, htd_pkg::DP_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_node = '0;
            end
            htd_pkg::DP_ADD_LINK: begin
                wr_en = 1'b1;
                if (step_bit) begin
                    wr_node.has_r = 1'b1;
                    wr_node.right = new_idx;
                end else begin
                    wr_node.has_l = 1'b1;
                    wr_node.left  = new_idx;
                end
            end
            htd_pkg::DP_ADD_NEW: begin
                wr_en   = 1'b1;
                wr_addr = new_idx;
                wr_node = '0;
            end
            htd_pkg::DP_ADD_SYM: begin
                wr_en       = 1'b1;
                wr_node.sym = r_sym;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_rem        = r_rem;
        n_node       = r_node;
        n_used       = r_used;
        n_walk       = r_walk;
        n_res_status = r_res_status;
        n_res_sym    = r_res_sym;
        n_out_valid  = r_out_valid && !i_out_ready;
        case (i_op)
            htd_pkg::DP_INIT_ROOT, htd_pkg::DP_CLEAR: begin
                n_used = CNTW'(1);
                n_walk = '0;
            end
            htd_pkg::DP_LOAD: begin
                n_rem        = len_clip;
                n_node       = (i_cmd == htd_pkg::CMD_DECODE) ? r_walk : '0;
                n_res_status = htd_pkg::ST_NONE;
                n_res_sym    = '0;
            end
            htd_pkg::DP_ADD_STEP: begin
                n_node = child_idx;
                n_rem  = r_rem - htd_pkg::LEN_W'(1);
            end
            htd_pkg::DP_ADD_NEW: begin
                n_node = new_idx;
                n_used = r_used + CNTW'(1);
                n_rem  = r_rem - htd_pkg::LEN_W'(1);
            end
            htd_pkg::DP_ADD_FULL: begin
                n_res_status = htd_pkg::ST_FULL;
            end
            htd_pkg::DP_DEC_STEP: begin
                n_node = child_idx;
            end
            htd_pkg::DP_DEC_CHECK: begin
                if (!rd_node.has_l && !rd_node.has_r) begin
                    n_res_status = htd_pkg::ST_SYMBOL;
                    n_res_sym    = rd_node.sym;
                    n_walk       = '0;
                end else begin
                    n_walk = r_node;
                end
            end
            htd_pkg::DP_OUT_LOAD: begin
                n_out_valid = 1'b1;
            end
            default: begin
                n_rem = r_rem;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= CNTW'(1);
            r_walk      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_used      <= n_used;
            r_walk      <= n_walk;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == htd_pkg::DP_LOAD) begin
            r_cmd      <= i_cmd;
            r_sym      <= i_symbol;
            r_code     <= i_code_bits;
            r_code_bit <= i_code_bit;
        end
        if (i_op == htd_pkg::DP_OUT_LOAD) begin
            r_out_status <= r_res_status;
            r_out_sym    <= r_res_sym;
        end
        r_rem        <= n_rem;
        r_node       <= n_node;
        r_res_status <= n_res_status;
        r_res_sym    <= n_res_sym;
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_out_symbol = r_out_sym;

endmodule

/* sv/htd_ctrl.sv */
// Controller of the Huffman tree decoder: the state machine that sequences
// datapath operations. Depends on htd_pkg.
module htd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  htd_pkg::t_dp_stat  i_stat,
    output htd_pkg::t_dp_op    o_op
);

    typedef enum logic [10:0] {
        S_INIT    = 11'b000_0000_0001,
        S_IDLE    = 11'b000_0000_0010,
        S_CLEAR   = 11'b000_0000_0100,
        S_ADD_RD  = 11'b000_0000_1000,
        S_ADD_EV  = 11'b000_0001_0000,
        S_ADD_NEW = 11'b000_0010_0000,
        S_DEC_RD  = 11'b000_0100_0000,
        S_DEC_EV  = 11'b000_1000_0000,
        S_DEC_CRD = 11'b001_0000_0000,
        S_DEC_CHK = 11'b010_0000_0000,
        S_FIN     = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_op       = htd_pkg::DP_NOP;
        o_in_ready = 1'b0;
        case (r_state)
            S_INIT: begin
                o_op    = htd_pkg::DP_INIT_ROOT;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_op = htd_pkg::DP_LOAD;
                    case (i_stat.new_cmd)
                        htd_pkg::CMD_CLEAR:  n_state = S_CLEAR;
                        htd_pkg::CMD_ADD:    n_state = S_ADD_RD;
                        htd_pkg::CMD_DECODE: n_state = S_DEC_RD;
                        default:             n_state = S_FIN;
                    endcase
                end
            end
            S_CLEAR: begin
                o_op    = htd_pkg::DP_CLEAR;
                n_state = S_FIN;
            end
            S_ADD_RD: begin
                n_state = S_ADD_EV;
            end
            S_ADD_EV: begin
                if (i_stat.rem_zero) begin
                    o_op    = htd_pkg::DP_ADD_SYM;
                    n_state = S_FIN;
                end else if (i_stat.child_present) begin
                    o_op    = htd_pkg::DP_ADD_STEP;
                    n_state = S_ADD_RD;
                end else if (i_stat.table_full) begin
                    o_op    = htd_pkg::DP_ADD_FULL;
                    n_state = S_FIN;
                end else begin
                    o_op    = htd_pkg::DP_ADD_LINK;
                    n_state = S_ADD_NEW;
                end
            end
            S_ADD_NEW: begin
                o_op    = htd_pkg::DP_ADD_NEW;
                n_state = S_ADD_RD;
            end
            S_DEC_RD: begin
                n_state = S_DEC_EV;
            end
            S_DEC_EV: begin
                if (i_stat.child_present) begin
                    o_op    = htd_pkg::DP_DEC_STEP;
                    n_state = S_DEC_CRD;
                end else begin
                    o_op    = htd_pkg::DP_DEC_CHECK;
                    n_state = S_FIN;
                end
            end
            S_DEC_CRD: begin
                n_state = S_DEC_CHK;
            end
            S_DEC_CHK: begin
                o_op    = htd_pkg::DP_DEC_CHECK;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_op    = htd_pkg::DP_OUT_LOAD;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* sv/htd_checker.sv */
// Port-level checker of the Huffman tree decoder and its bind to the top level.
// Depends on htd_pkg and huffman_tree_decoder_defines.svh.
`include "huffman_tree_decoder_defines.svh"

module htd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [htd_pkg::STATUS_W-1:0]  i_status,
    input logic [htd_pkg::SYM_W-1:0]     i_out_symbol
);

    logic                                        out_stall;
    logic [htd_pkg::STATUS_W+htd_pkg::SYM_W-1:0] out_payload;
    logic                                        status_ok;

    assign out_stall   = i_out_valid && !i_out_ready;
    assign out_payload = {i_status, i_out_symbol};
    assign status_ok   = (i_status == htd_pkg::ST_NONE) || (i_status == htd_pkg::ST_SYMBOL)
                         || (i_status == htd_pkg::ST_FULL);

    // Only one item is in work, so a transfer drops ready for the next cycle.
    `HTD_ASSERT_NXT(a_one_item, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // A stalled result holds its payload.
    `HTD_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_stall, i_out_valid && $stable(out_payload))

    // A new result appears only when the block had no item open for input.
    `HTD_ASSERT_IMP(a_out_after_work, i_clk, i_rst_n, $rose(i_out_valid), !$past(i_in_ready))

    // Status is never the unused code.
    `HTD_ASSERT_IMP(a_status_code, i_clk, i_rst_n, i_out_valid, status_ok)

endmodule

bind huffman_tree_decoder htd_checker u_htd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_status     (o_out.status),
    .i_out_symbol (o_out.out_symbol)
);

/* tb/sv/htd_tb_pkg.sv */
`timescale 1ns / 100ps
// Scoreboard for the Huffman tree decoder testbench: a mirror of the node table and walk
// that predicts every result, and a queue of the results still awaited. Depends on htd_pkg.
package htd_tb_pkg;

    localparam logic [htd_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int NODES      = htd_pkg::NODE_COUNT_DEF;
    localparam int CODE_LIMIT = htd_pkg::MAX_CODE_LEN_DEF;
    localparam int LINK_W     = $clog2(NODES);

    typedef struct packed {
        logic [htd_pkg::STATUS_W-1:0] status;
        logic [htd_pkg::SYM_W-1:0]    symbol;
    } t_tree_result;

    class t_walk_scoreboard;
        logic [LINK_W-1:0]         left_link [NODES];
        logic [LINK_W-1:0]         right_link [NODES];
        bit                        has_left [NODES];
        bit                        has_right [NODES];
        logic [htd_pkg::SYM_W-1:0] node_symbol [NODES];
        int                        nodes_used;
        int                        walk_node;
        int                        mismatches;
        t_tree_result              awaited [$];

        function new();
            for (int n = 0; n < NODES; n++) fresh_node(n);
            nodes_used = 1;
            walk_node  = 0;
            mismatches = 0;
        endfunction

        function void fresh_node(int n);
            left_link[n]   = '0;
            right_link[n]  = '0;
            has_left[n]    = 1'b0;
            has_right[n]   = 1'b0;
            node_symbol[n] = '0;
        endfunction

        // Walks the code from the root, most significant used bit first, growing the tree.
        function logic [htd_pkg::STATUS_W-1:0] insert_code(
                logic [htd_pkg::SYM_W-1:0] sym,
                logic [htd_pkg::CODE_W-1:0] bits,
                logic [htd_pkg::LEN_W-1:0] len);
            int node;
            int used_len;
            bit b;
            node     = 0;
            used_len = (int'(len) > CODE_LIMIT) ? CODE_LIMIT : int'(len);
            for (int k = used_len - 1; k >= 0; k--) begin
                b = (k < htd_pkg::CODE_W) ? bits[k] : 1'b0;
                if (b ? !has_right[node] : !has_left[node]) begin
                    if (nodes_used >= NODES) return htd_pkg::ST_FULL;
                    fresh_node(nodes_used);
                    if (b) begin
                        right_link[node] = LINK_W'(nodes_used);
                        has_right[node]  = 1'b1;
                    end else begin
                        left_link[node] = LINK_W'(nodes_used);
                        has_left[node]  = 1'b1;
                    end
                    nodes_used++;
                end
                node = b ? int'(right_link[node]) : int'(left_link[node]);
            end
            node_symbol[node] = sym;
            return htd_pkg::ST_NONE;
        endfunction

        function void note_command(logic [htd_pkg::CMD_W-1:0] cmd,
                                   logic [htd_pkg::SYM_W-1:0] sym,
                                   logic [htd_pkg::CODE_W-1:0] bits,
                                   logic [htd_pkg::LEN_W-1:0] len,
                                   logic code_bit);
            t_tree_result r;
            int n;
            r.status = htd_pkg::ST_NONE;
            r.symbol = '0;
            case (cmd)
                htd_pkg::CMD_CLEAR: begin
                    fresh_node(0);
                    nodes_used = 1;
                    walk_node  = 0;
                end
                htd_pkg::CMD_ADD: r.status = insert_code(sym, bits, len);
                htd_pkg::CMD_DECODE: begin
                    n = walk_node;
                    if (code_bit) begin
                        if (has_right[n]) n = int'(right_link[n]);
                    end else if (has_left[n]) begin
                        n = int'(left_link[n]);
                    end
                    if (!has_left[n] && !has_right[n]) begin
                        r.status = htd_pkg::ST_SYMBOL;
                        r.symbol = node_symbol[n];
                        n        = 0;
                    end
                    walk_node = n;
                end
                default: ;
            endcase
            awaited.push_back(r);
        endfunction

        function void check_result(logic [htd_pkg::STATUS_W-1:0] status,
                                   logic [htd_pkg::SYM_W-1:0] symbol);
            t_tree_result want;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with nothing awaited: status %0d symbol %02h",
                             status, symbol);
                return;
            end
            want = awaited.pop_front();
            if (status !== want.status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("status mismatch: expected %0d got %0d", want.status, status);
            end
            if (symbol !== want.symbol) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("out_symbol mismatch: expected %02h got %02h",
                             want.symbol, symbol);
            end
        endfunction
    endclass

endpackage

/* tb/sv/tb_huffman_tree_decoder.sv */
`timescale 1ns / 100ps
// Top of the Huffman tree decoder testbench: clock, reset, bursty command source,
// stalling result sink, directed and random tree builds. Depends on htd_pkg, htd_if,
// htd_tb_pkg and the decoder RTL.
module tb_huffman_tree_decoder;

    localparam int IDLE_LIMIT  = 4000;
    localparam int ITEM_TARGET = 2000;

    logic clk = 1'b0;
    logic rst_n;

    htd_in_if  in_ch ();
    htd_out_if out_ch ();

    huffman_tree_decoder DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    htd_tb_pkg::t_walk_scoreboard tracker;

    int          burst_left;
    int          gap_max;
    int          work_items;
    int          idle_cycles;
    logic [5:0]  rx_count;
    logic [15:0] rx_pattern;
    logic        rx_always;

    always #6 clk = ~clk;

    always @(posedge clk) begin
        if (rx_count == 0) begin
            rx_always     = ($urandom_range(0, 3) == 0);
            rx_pattern    = 16'($urandom);
            rx_pattern[0] = 1'b1;
        end
        out_ch.ready <= rx_always || rx_pattern[rx_count[3:0]];
        rx_count = rx_count + 6'd1;
    end

    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready)
            tracker.check_result(out_ch.status, out_ch.out_symbol);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_huffman_tree_decoder: errors");
            $finish;
        end
    end

    task automatic send_item(input logic [htd_pkg::CMD_W-1:0] cmd,
                             input logic [htd_pkg::SYM_W-1:0] sym,
                             input logic [htd_pkg::CODE_W-1:0] bits,
                             input logic [htd_pkg::LEN_W-1:0] len,
                             input logic code_bit);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap != 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_ch.valid       <= 1'b1;
        in_ch.cmd         <= cmd;
        in_ch.symbol      <= sym;
        in_ch.code_bits   <= bits;
        in_ch.code_length <= len;
        in_ch.code_bit    <= code_bit;
        @(posedge clk);
        while (in_ch.ready !== 1'b1) @(posedge clk);
        tracker.note_command(cmd, sym, bits, len, code_bit);
        if (cmd != htd_tb_pkg::CMD_UNUSED) work_items++;
    endtask

    task automatic decode_bit(input logic b);
        send_item(htd_pkg::CMD_DECODE, htd_pkg::SYM_W'($urandom), $urandom,
                  htd_pkg::LEN_W'($urandom), b);
    endtask

    task automatic clear_tree();
        send_item(htd_pkg::CMD_CLEAR, htd_pkg::SYM_W'($urandom), $urandom,
                  htd_pkg::LEN_W'($urandom), 1'($urandom));
    endtask

    task automatic add_code(input logic [htd_pkg::SYM_W-1:0] sym,
                            input logic [htd_pkg::CODE_W-1:0] bits,
                            input logic [htd_pkg::LEN_W-1:0] len);
        send_item(htd_pkg::CMD_ADD, sym, bits, len, 1'($urandom));
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (tracker.awaited.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Builds a complete prefix code by splitting random leaves, loads it with a few
    // entries sometimes missing, then decodes random bits with stray commands mixed in.
    task automatic code_phase();
        int unsigned code_v [$];
        int          code_l [$];
        int          leaves;
        int          pick;
        int          count;
        int unsigned v;
        int          l;
        code_v.push_back(0);
        code_l.push_back(0);
        leaves = $urandom_range(2, 24);
        while (code_v.size() < leaves) begin
            pick = $urandom_range(0, code_v.size() - 1);
            v = code_v[pick];
            l = code_l[pick];
            code_v[pick] = v << 1;
            code_l[pick] = l + 1;
            code_v.push_back((v << 1) | 1);
            code_l.push_back(l + 1);
        end
        clear_tree();
        foreach (code_v[i]) begin
            if ($urandom_range(0, 7) != 0)
                add_code(htd_pkg::SYM_W'($urandom), ($urandom << code_l[i]) | code_v[i],
                         htd_pkg::LEN_W'(code_l[i]));
        end
        count = $urandom_range(20, 100);
        repeat (count) begin
            pick = $urandom_range(0, 39);
            if (pick == 0)
                send_item(htd_tb_pkg::CMD_UNUSED, htd_pkg::SYM_W'($urandom), $urandom,
                          htd_pkg::LEN_W'($urandom), 1'($urandom));
            else if (pick == 1)
                add_code(htd_pkg::SYM_W'($urandom), $urandom,
                         htd_pkg::LEN_W'($urandom_range(0, 6)));
            else
                decode_bit(1'($urandom_range(0, 1)));
        end
    endtask

    task automatic noise_phase();
        logic [htd_pkg::CMD_W-1:0] cmd;
        int                        count;
        count = $urandom_range(10, 40);
        repeat (count) begin
            cmd = htd_pkg::CMD_W'($urandom_range(0, 3));
            if (cmd == htd_pkg::CMD_CLEAR && $urandom_range(0, 3) != 0)
                cmd = htd_pkg::CMD_DECODE;
            send_item(cmd, htd_pkg::SYM_W'($urandom), $urandom,
                      htd_pkg::LEN_W'($urandom), 1'($urandom));
        end
    endtask

    // Grows long codes until the node table is exhausted, then adds and decodes on it.
    task automatic fill_phase();
        logic [htd_pkg::CODE_W-1:0] first_bits;
        logic [htd_pkg::LEN_W-1:0]  first_len;
        first_bits = $urandom;
        first_len  = htd_pkg::LEN_W'($urandom_range(24, 32));
        clear_tree();
        add_code(htd_pkg::SYM_W'($urandom), first_bits, first_len);
        while (tracker.nodes_used < htd_tb_pkg::NODES)
            add_code(htd_pkg::SYM_W'($urandom), $urandom,
                     htd_pkg::LEN_W'($urandom_range(24, 63)));
        repeat (3)
            add_code(htd_pkg::SYM_W'($urandom), $urandom,
                     htd_pkg::LEN_W'($urandom_range(1, 40)));
        add_code(htd_pkg::SYM_W'($urandom), first_bits, first_len);
        repeat (40) decode_bit(1'($urandom_range(0, 1)));
    endtask

    initial begin
        int pick;
        int round;
        tracker           = new();
        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.cmd         = htd_pkg::CMD_CLEAR;
        in_ch.symbol      = '0;
        in_ch.code_bits   = '0;
        in_ch.code_length = '0;
        in_ch.code_bit    = 1'b0;
        out_ch.ready      = 1'b0;
        rx_count          = '0;
        rx_always         = 1'b1;
        rx_pattern        = '1;
        burst_left        = 0;
        gap_max           = 0;
        work_items        = 0;
        idle_cycles       = 0;
        round             = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // A childless root emits its symbol on every bit.
        decode_bit(1'b0);
        decode_bit(1'b1);
        send_item(htd_tb_pkg::CMD_UNUSED, '1, '1, '1, 1'b1);
        add_code(8'hFF, 32'hFFFF_FFFF, 6'd0);
        decode_bit(1'b1);
        // Over-long length is cut to the maximum code length.
        add_code(8'hA5, 32'hFFFF_FFFF, 6'd63);
        add_code(8'h5A, 32'h0000_0000, 6'd32);
        decode_bit(1'b1);
        decode_bit(1'b0);
        clear_tree();
        add_code(8'h00, 32'h0, 6'd1);
        add_code(8'hFF, 32'h1, 6'd1);
        decode_bit(1'b0);
        decode_bit(1'b1);
        // A former leaf gains a child, and a step to its missing child stays put.
        add_code(8'h55, 32'h2, 6'd2);
        decode_bit(1'b1);
        decode_bit(1'b1);
        decode_bit(1'b0);
        add_code(8'h81, 32'h8000_0001, 6'd32);
        send_item(htd_tb_pkg::CMD_UNUSED, '0, '0, '0, 1'b0);
        clear_tree();
        decode_bit(1'b0);
        drain_results();

        while (work_items < ITEM_TARGET) begin
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            pick = $urandom_range(0, 15);
            if (round == 0 || pick == 15)
                fill_phase();
            else if (pick < 11)
                code_phase();
            else
                noise_phase();
            if ($urandom_range(0, 3) == 0) drain_results();
            round++;
        end

        in_ch.valid <= 1'b0;
        while (tracker.awaited.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("tb_huffman_tree_decoder: clean");
        else
            $display("tb_huffman_tree_decoder: errors");
        $finish;
    end

endmodule
